### rtl/apq_pkg.sv
package apq_pkg;

	localparam int PRIO_W   = 16;
	localparam int OCC_W    = 8;
	localparam int STATUS_W = 2;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_POP    = 1'b1;

	localparam logic TAG_ACCEPTED = 1'b0;
	localparam logic TAG_DENIED   = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

	typedef struct packed {
		logic                     func;
		logic signed [PRIO_W-1:0] prio;
		logic                     decision;
	} in_t;

	typedef struct packed {
		logic [STATUS_W-1:0]      status;
		logic signed [PRIO_W-1:0] out_prio;
		logic                     out_decision;
		logic [OCC_W-1:0]         occupancy;
	} out_t;

	// controller to datapath
	typedef struct packed {
		logic latch;
		logic exec;
		logic scan;
		logic shift;
		logic finish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_pop;
		logic empty;
		logic scan_last;
		logic shift_last;
		logic out_free;
	} stat_t;

endpackage

### rtl/apq_ctrl.sv
module apq_ctrl
	import apq_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_EXEC  = 5'b00010,
		ST_SCAN  = 5'b00100,
		ST_SHIFT = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.latch = in_valid;
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				if (stat.is_pop && !stat.empty) begin
					state_d = ST_SCAN;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_last) begin
					state_d = ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				cmd.shift = 1'b1;
				if (stat.shift_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				cmd.finish = stat.out_free;
				if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### rtl/apq_datapath.sv
module apq_datapath
	import apq_pkg::*;
#(
	parameter int DEPTH     = 128,
	parameter int PRIO_BITS = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	input  in_t   in_data,
	input  cmd_t  cmd,
	output stat_t stat,
	output logic  out_valid,
	input  logic  out_ready,
	output out_t  out_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int EW = PRIO_BITS + 1;
	localparam int PW = (PRIO_BITS > PRIO_W) ? PRIO_BITS : PRIO_W;
	localparam int OW = (CW > OCC_W) ? CW : OCC_W;

	// entry layout: tag on top, priority below
	logic [EW-1:0] mem [DEPTH];

	in_t             req_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   ptr_q;
	logic [EW-1:0]   rd_data_q;
	logic [AW-1:0]   rd_idx_q;
	logic            rd_valid_q;
	logic [EW-1:0]   best_q;
	logic [AW-1:0]   best_idx_q;
	logic            first_q;
	logic [STATUS_W-1:0] res_status_q;
	logic            out_valid_q;
	out_t            out_q;

	logic            full;
	logic            empty;
	logic [AW-1:0]   rd_addr;
	logic            we;
	logic [AW-1:0]   wa;
	logic [EW-1:0]   wd;
	logic [PW-1:0]   prio_ext;
	logic [PW-1:0]   best_ext;
	logic [OW-1:0]   count_ext;
	logic            take;
	logic [AW-1:0]   best_idx_d;
	logic            scan_last;
	logic            shift_more;
	logic [CW-1:0]   ptr_inc;

	function automatic logic beats(input logic [EW-1:0] a, input logic [EW-1:0] b);
		logic signed [PRIO_BITS-1:0] pa;
		logic signed [PRIO_BITS-1:0] pb;
		pa = a[PRIO_BITS-1:0];
		pb = b[PRIO_BITS-1:0];
		if (pa != pb) begin
			return pa > pb;
		end
		return (a[PRIO_BITS] == TAG_ACCEPTED) && (b[PRIO_BITS] == TAG_DENIED);
	endfunction

	assign full       = (count_q == CW'(DEPTH));
	assign empty      = (count_q == '0);
	assign ptr_inc    = ptr_q + CW'(1);
	assign prio_ext   = PW'($unsigned(req_q.prio));
	assign best_ext   = PW'(best_q[PRIO_BITS-1:0]);
	assign count_ext  = OW'(count_q);

	// compare stage: rd_data_q holds entry rd_idx_q
	assign take       = cmd.scan && rd_valid_q && (first_q || beats(rd_data_q, best_q));
	assign best_idx_d = take ? rd_idx_q : best_idx_q;
	assign scan_last  = rd_valid_q && ((CW'(rd_idx_q) + CW'(1)) == count_q);
	// one bit wider so that ptr_q + 1 cannot wrap when ptr_q has reached the count
	assign shift_more = (({1'b0, ptr_q} + (CW+1)'(1)) < {1'b0, count_q});

	assign stat.is_pop     = (req_q.func == FUNC_POP);
	assign stat.empty      = empty;
	assign stat.scan_last  = scan_last;
	assign stat.shift_last = !shift_more && !rd_valid_q;
	assign stat.out_free   = !out_valid_q || out_ready;

	always_comb begin
		rd_addr = ptr_q[AW-1:0];
		if (cmd.exec) begin
			rd_addr = '0;
		end else if (cmd.shift) begin
			rd_addr = ptr_inc[AW-1:0];
		end
	end

	always_comb begin
		we = 1'b0;
		wa = count_q[AW-1:0];
		wd = {req_q.decision, prio_ext[PRIO_BITS-1:0]};
		if (cmd.exec && req_q.func == FUNC_INSERT && !full) begin
			we = 1'b1;
		end else if (cmd.shift && rd_valid_q) begin
			we = 1'b1;
			wa = rd_idx_q;
			wd = rd_data_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q <= in_data;
		end
		if (take) begin
			best_q <= rd_data_q;
		end
		best_idx_q <= best_idx_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			ptr_q        <= '0;
			rd_idx_q     <= '0;
			rd_valid_q   <= 1'b0;
			first_q      <= 1'b0;
			res_status_q <= STATUS_OK;
		end else begin
			if (cmd.exec) begin
				res_status_q <= STATUS_OK;
				if (req_q.func == FUNC_INSERT) begin
					if (full) begin
						res_status_q <= STATUS_FULL;
					end else begin
						count_q <= count_q + CW'(1);
					end
				end else if (empty) begin
					res_status_q <= STATUS_EMPTY;
				end else begin
					ptr_q      <= CW'(1);
					rd_idx_q   <= '0;
					rd_valid_q <= 1'b1;
					first_q    <= 1'b1;
				end
			end
			if (cmd.scan) begin
				if (rd_valid_q) begin
					first_q <= 1'b0;
				end
				if (scan_last) begin
					// hand over to the shift with the winner's slot
					ptr_q      <= CW'(best_idx_d);
					rd_valid_q <= 1'b0;
				end else begin
					ptr_q      <= ptr_inc;
					rd_idx_q   <= ptr_q[AW-1:0];
					rd_valid_q <= (ptr_q < count_q);
				end
			end
			if (cmd.shift) begin
				if (!shift_more && !rd_valid_q) begin
					count_q <= count_q - CW'(1);
				end else begin
					rd_idx_q   <= ptr_q[AW-1:0];
					rd_valid_q <= shift_more;
					ptr_q      <= ptr_inc;
				end
			end
		end
	end

	// result register, parts the controller from the output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q.status       <= res_status_q;
			out_q.occupancy    <= count_ext[OCC_W-1:0];
			out_q.out_prio     <= '0;
			out_q.out_decision <= 1'b0;
			if (req_q.func == FUNC_POP && res_status_q == STATUS_OK) begin
				out_q.out_prio     <= best_ext[PRIO_W-1:0];
				out_q.out_decision <= best_q[PRIO_BITS];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

### rtl/array_priority_queue_tiebreak_top.sv
// Insert, pop on an empty table and insert into a full table go straight from the execute step to the result.
// Pop of n held entries: the scan reads the n entries to find the winner, then the shift-down moves the entries
// above the winner's slot down by one; one item is worked on at a time.
// A new item is taken while the previous result waits in the output register.
// Reset clears the controller, the fill count and the output valid; the entry memory is not cleared.
module array_priority_queue_tiebreak_top
	import apq_pkg::*;
#(
	parameter int DEPTH     = 128,
	parameter int PRIO_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	cmd_t  cmd;
	stat_t stat;

	apq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	apq_datapath #(
		.DEPTH     (DEPTH),
		.PRIO_BITS (PRIO_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

### tb/array_priority_queue_tiebreak_top_test.sv
module array_priority_queue_tiebreak_top_test;
	import apq_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUEUE_DEPTH  = 128;
	localparam int QUIET_LIMIT  = 5000;
	localparam int HOLD_CYCLES  = 600;
	localparam int HOLD_AFTER   = 1000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t  in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;

	array_priority_queue_tiebreak_top #(
		.DEPTH(QUEUE_DEPTH),
		.PRIO_BITS(PRIO_W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// table as the block should hold it
	logic signed [PRIO_W-1:0] held_prio [QUEUE_DEPTH];
	logic                     held_tag  [QUEUE_DEPTH];
	int                       held_count = 0;

	in_t  pending_ops [$];
	out_t expected_results [$];
	int   ops_queued = 0;
	int   results_done = 0;
	int   fault_count = 0;
	int   quiet_cycles = 0;
	int   hold_left = 0;
	bit   hold_done = 1'b0;
	bit   calm = 1'b0;

	function automatic out_t apply_op(in_t op);
		out_t res;
		int   best;
		res = '0;
		if (op.func == FUNC_INSERT) begin
			if (held_count >= QUEUE_DEPTH) begin
				res.status = STATUS_FULL;
			end else begin
				held_prio[held_count] = op.prio;
				held_tag[held_count]  = op.decision;
				held_count++;
			end
		end else if (held_count == 0) begin
			res.status = STATUS_EMPTY;
		end else begin
			best = 0;
			// strict compare keeps the earliest of equal entries
			for (int i = 1; i < held_count; i++)
				if (held_prio[i] > held_prio[best] ||
				    (held_prio[i] == held_prio[best] && held_tag[i] < held_tag[best]))
					best = i;
			res.out_prio     = held_prio[best];
			res.out_decision = held_tag[best];
			for (int i = best; i + 1 < held_count; i++) begin
				held_prio[i] = held_prio[i + 1];
				held_tag[i]  = held_tag[i + 1];
			end
			held_count--;
		end
		res.occupancy = held_count[OCC_W-1:0];
		return res;
	endfunction

	// biased towards a few values so that ties turn up often
	function automatic logic signed [PRIO_W-1:0] pick_prio();
		case ($urandom_range(0, 3))
			0: return PRIO_W'($urandom);
			1: return PRIO_W'($urandom_range(0, 6)) - PRIO_W'(3);
			2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			default: return PRIO_W'($urandom_range(0, 40)) - PRIO_W'(20);
		endcase
	endfunction

	task automatic queue_op(logic func, logic signed [PRIO_W-1:0] prio, logic tag);
		in_t op;
		op.func     = func;
		op.prio     = prio;
		op.decision = tag;
		pending_ops.push_back(op);
		ops_queued++;
	endtask

	task automatic queue_random(int count, int insert_pct);
		repeat (count)
			queue_op(($urandom_range(0, 99) < insert_pct) ? FUNC_INSERT : FUNC_POP,
			         pick_prio(), 1'($urandom));
	endtask

	task automatic wait_all_done();
		while (results_done != ops_queued)
			@(posedge clk);
	endtask

	// sender
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				expected_results.push_back(apply_op(in_data));
			if (!in_valid || in_ready) begin
				if (pending_ops.size() != 0 && (calm || $urandom_range(0, 99) >= 6)) begin
					in_data  <= pending_ops.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver, with one long hold-off once enough results have come
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && results_done >= HOLD_AFTER) begin
			out_ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			out_ready <= calm || $urandom_range(0, 99) >= 6;
		end
	end

	task automatic check_field(string field, logic signed [31:0] want, logic signed [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			fault_count++;
		end
	endtask

	always @(posedge clk) begin
		out_t want;
		if (arst_n && out_valid && out_ready) begin
			results_done++;
			if (expected_results.size() == 0) begin
				$error("result transfer with nothing expected: %p", out_data);
				fault_count++;
			end else begin
				want = expected_results.pop_front();
				check_field("status", want.status, out_data.status);
				check_field("out_prio", want.out_prio, out_data.out_prio);
				check_field("out_decision", want.out_decision, out_data.out_decision);
				check_field("occupancy", want.occupancy, out_data.occupancy);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("array_priority_queue_tiebreak_top test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// empty pop, ties on priority and tag, both priority extremes
		queue_op(FUNC_POP, pick_prio(), 1'($urandom));
		queue_op(FUNC_INSERT, 16'sh7fff, TAG_DENIED);
		queue_op(FUNC_INSERT, 16'sh7fff, TAG_ACCEPTED);
		queue_op(FUNC_INSERT, 16'sh8000, TAG_ACCEPTED);
		queue_op(FUNC_INSERT, 16'sh8000, TAG_DENIED);
		queue_op(FUNC_INSERT, 16'sd5, TAG_ACCEPTED);
		queue_op(FUNC_INSERT, 16'sd5, TAG_ACCEPTED);
		queue_op(FUNC_INSERT, 16'sd5, TAG_DENIED);
		repeat (8)
			queue_op(FUNC_POP, pick_prio(), 1'($urandom));
		// lone most-negative entry must still come out
		queue_op(FUNC_INSERT, 16'sh8000, TAG_DENIED);
		queue_op(FUNC_POP, 16'sh7fff, TAG_ACCEPTED);
		queue_op(FUNC_INSERT, -16'sd1, TAG_DENIED);
		queue_op(FUNC_INSERT, 16'sd0, TAG_DENIED);
		queue_op(FUNC_INSERT, -16'sd1, TAG_ACCEPTED);
		repeat (4)
			queue_op(FUNC_POP, 16'sh0000, TAG_DENIED);
		wait_all_done();

		queue_random(600, 55);
		wait_all_done();

		// overfill then drain past empty, no idling on either side
		calm = 1'b1;
		repeat (140)
			queue_op(FUNC_INSERT, pick_prio(), 1'($urandom));
		repeat (135)
			queue_op(FUNC_POP, pick_prio(), 1'($urandom));
		wait_all_done();
		calm = 1'b0;

		for (int seg = 0; seg < 10; seg++) begin
			case ($urandom_range(0, 3))
				0: queue_random(95, 30);
				1: queue_random(95, 50);
				2: queue_random(95, 70);
				default: queue_random(95, 90);
			endcase
		end
		wait_all_done();

		repeat (2 * QUEUE_DEPTH + 8) @(posedge clk);
		if (fault_count == 0 && expected_results.size() == 0) begin
			$display("array_priority_queue_tiebreak_top test passed");
		end else begin
			$display("array_priority_queue_tiebreak_top test failed");
		end
		$finish;
	end

endmodule
